[hdl/floppy_controller_registers_defines.svh]
// Assertion macros for the floppy controller register block.
// Each macro takes a label, a clock, an active-low reset, a trigger and a consequence.
`ifndef FLOPPY_CONTROLLER_REGISTERS_DEFINES_SVH
`define FLOPPY_CONTROLLER_REGISTERS_DEFINES_SVH

`ifndef SYNTHESIS

`define FCR_ASSERT_SAME(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

`define FCR_ASSERT_NEXT(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`else

`define FCR_ASSERT_SAME(label, clk, rst_n, trig, cons)
`define FCR_ASSERT_NEXT(label, clk, rst_n, trig, cons)

`endif

`endif

[hdl/fcr_pkg.sv]
package fcr_pkg;

    localparam int SECTOR_BYTES_DEF = 512;
    localparam int LAST_TRACK_DEF   = 79;

    localparam int BYTE_W = 8;
    localparam int ADDR_W = 22;
    localparam int PORT_W = 3;
    localparam int CMD_W  = 4;

    // Sectors per track over both sides, and per side.
    localparam int TRACK_SECTORS = 18;
    localparam int SIDE_SECTORS  = 9;
    localparam int SIDE_BIT      = 4;

    localparam logic [BYTE_W-1:0] STATUS_RD_FLAG = 8'h40;
    localparam logic [BYTE_W-1:0] NO_DATA        = 8'hFF;
    localparam logic [BYTE_W-1:0] ZERO_BYTE      = 8'h00;

    localparam int STAT_TRACK0_BIT = 2;
    localparam int STAT_DRQ_BIT    = 1;
    localparam int STAT_BUSY_BIT   = 0;

    localparam logic [PORT_W-1:0] PORT_CMD    = 3'd0;
    localparam logic [PORT_W-1:0] PORT_TRACK  = 3'd1;
    localparam logic [PORT_W-1:0] PORT_SECTOR = 3'd2;
    localparam logic [PORT_W-1:0] PORT_DATA   = 3'd3;
    localparam logic [PORT_W-1:0] PORT_SIDE   = 3'd4;

    localparam logic [CMD_W-1:0] CMD_RESTORE     = 4'h0;
    localparam logic [CMD_W-1:0] CMD_SEEK        = 4'h1;
    localparam logic [CMD_W-1:0] CMD_STEP        = 4'h2;
    localparam logic [CMD_W-1:0] CMD_STEP_U      = 4'h3;
    localparam logic [CMD_W-1:0] CMD_STEP_IN     = 4'h4;
    localparam logic [CMD_W-1:0] CMD_STEP_IN_U   = 4'h5;
    localparam logic [CMD_W-1:0] CMD_STEP_OUT    = 4'h6;
    localparam logic [CMD_W-1:0] CMD_STEP_OUT_U  = 4'h7;
    localparam logic [CMD_W-1:0] CMD_READ_SECTOR = 4'h8;
    localparam logic [CMD_W-1:0] CMD_FORCE_INT   = 4'hD;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        K_STATUS_RD,
        K_TRACK_RD,
        K_SECTOR_RD,
        K_DATA_RD,
        K_SIDE_RD,
        K_UNMAPPED_RD,
        K_COMMAND_WR,
        K_SECTOR_WR,
        K_DATA_WR,
        K_SIDE_WR,
        K_IGNORED_WR
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] data;
    } t_entry;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
    } t_queue_status;

endpackage

[hdl/fcr_channels.sv]
interface fcr_in_if;
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [fcr_pkg::PORT_W-1:0]    port;
    logic [fcr_pkg::BYTE_W-1:0]    write_data;
    logic [fcr_pkg::BYTE_W-1:0]    disk_byte;

    modport source (output valid, operation, port, write_data, disk_byte, input ready);
    modport sink   (input valid, operation, port, write_data, disk_byte, output ready);
endinterface

interface fcr_out_if;
    logic                          valid;
    logic                          ready;
    logic [fcr_pkg::BYTE_W-1:0]    read_data;
    logic [fcr_pkg::ADDR_W-1:0]    disk_address;

    modport source (output valid, read_data, disk_address, input ready);
    modport sink   (input valid, read_data, disk_address, output ready);
endinterface

interface fcr_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[hdl/floppy_controller_registers.sv]
// Floppy controller register file as seen from the CPU bus.
// i_in carries one bus access per word: operation, port, the write byte and the
// disk image byte at the current disk address. o_out returns one word for every
// access: the read byte (zero on writes) and the disk address after the access.
// i_cfg writes the disk present flag; it is always ready.
// An access is classified at the input and placed in a two-word queue; the back
// end executes one queued access per cycle into an output register while o_out
// does not stall. Throughput is one access per cycle when o_out is not stalled.
// The result passes through the queue and then the output register to o_out.
// When o_out stalls, the output register holds its word, the queue fills, and
// i_in.ready falls once both queue slots are taken; nothing is lost.
// Reset clears the state registers, sets disk present, and empties the queue and
// the output register; queue memory and output data and address are not reset.
`include "floppy_controller_registers_defines.svh"

module floppy_controller_registers #(
    parameter int SECTOR_BYTES = fcr_pkg::SECTOR_BYTES_DEF,
    parameter int LAST_TRACK   = fcr_pkg::LAST_TRACK_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fcr_in_if.sink       i_in,
    fcr_cfg_if.sink      i_cfg,
    fcr_out_if.source    o_out
);

    logic                      push_valid;
    logic                      push_ready;
    fcr_pkg::t_entry           push_entry;
    logic                      pop_valid;
    logic                      pop_ready;
    fcr_pkg::t_entry           pop_entry;
    fcr_pkg::t_queue_status    q_status;

    fcr_front u_front (
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_entry (push_entry)
    );

    fcr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_entry (push_entry),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_entry  (pop_entry),
        .o_status     (q_status)
    );

    fcr_back #(
        .SECTOR_BYTES (SECTOR_BYTES),
        .LAST_TRACK   (LAST_TRACK)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pop_valid  (pop_valid),
        .o_pop_ready  (pop_ready),
        .i_pop_entry  (pop_entry),
        .i_cfg        (i_cfg),
        .o_out        (o_out)
    );

    `FCR_ASSERT_SAME(a_queue_bound, i_clk, i_rst_n, 1'b1, q_status.count <= fcr_pkg::QCNT_W'(fcr_pkg::QUEUE_DEPTH))
    `FCR_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, i_in.valid && i_in.ready, q_status.count != '0)
    `FCR_ASSERT_NEXT(a_back_drains, i_clk, i_rst_n, pop_valid && !o_out.valid, o_out.valid)

endmodule

[hdl/fcr_front.sv]
module fcr_front (
    fcr_in_if.sink             i_in,
    output logic               o_push_valid,
    input  logic               i_push_ready,
    output fcr_pkg::t_entry    o_push_entry
);

    fcr_pkg::t_kind kind;

    always_comb begin
        if (i_in.operation) begin
            case (i_in.port)
                fcr_pkg::PORT_CMD:    kind = fcr_pkg::K_COMMAND_WR;
                fcr_pkg::PORT_SECTOR: kind = fcr_pkg::K_SECTOR_WR;
                fcr_pkg::PORT_DATA:   kind = fcr_pkg::K_DATA_WR;
                fcr_pkg::PORT_SIDE:   kind = fcr_pkg::K_SIDE_WR;
                default:              kind = fcr_pkg::K_IGNORED_WR;
            endcase
        end else begin
            case (i_in.port)
                fcr_pkg::PORT_CMD:    kind = fcr_pkg::K_STATUS_RD;
                fcr_pkg::PORT_TRACK:  kind = fcr_pkg::K_TRACK_RD;
                fcr_pkg::PORT_SECTOR: kind = fcr_pkg::K_SECTOR_RD;
                fcr_pkg::PORT_DATA:   kind = fcr_pkg::K_DATA_RD;
                fcr_pkg::PORT_SIDE:   kind = fcr_pkg::K_SIDE_RD;
                default:              kind = fcr_pkg::K_UNMAPPED_RD;
            endcase
        end
    end

    // Every read carries the disk byte; every write carries its write word.
    assign o_push_entry.kind = kind;
    assign o_push_entry.data = i_in.operation ? i_in.write_data : i_in.disk_byte;
    assign o_push_valid      = i_in.valid;
    assign i_in.ready        = i_push_ready;

endmodule

[hdl/fcr_queue.sv]
module fcr_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push_valid,
    output logic                      o_push_ready,
    input  fcr_pkg::t_entry           i_push_entry,
    output logic                      o_pop_valid,
    input  logic                      i_pop_ready,
    output fcr_pkg::t_entry           o_pop_entry,
    output fcr_pkg::t_queue_status    o_status
);

    localparam int DEPTH = fcr_pkg::QUEUE_DEPTH;
    localparam int PW    = fcr_pkg::QPTR_W;
    localparam int CW    = fcr_pkg::QCNT_W;

    fcr_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            push;
    logic            pop;
    logic            full;

    assign full         = (r_count == CW'(DEPTH));
    assign o_push_ready = !full;
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_entry  = r_mem[r_rd_ptr];
    assign push         = i_push_valid && !full;
    assign pop          = o_pop_valid && i_pop_ready;

    assign o_status.count = r_count;
    assign o_status.full  = full;

    function automatic logic [PW-1:0] f_wrap(input logic [PW-1:0] ptr);
        f_wrap = (ptr == PW'(DEPTH - 1)) ? '0 : ptr + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= f_wrap(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= f_wrap(r_rd_ptr);
            end
            if (push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

[hdl/fcr_back.sv]
module fcr_back #(
    parameter int SECTOR_BYTES = fcr_pkg::SECTOR_BYTES_DEF,
    parameter int LAST_TRACK   = fcr_pkg::LAST_TRACK_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_pop_valid,
    output logic               o_pop_ready,
    input  fcr_pkg::t_entry    i_pop_entry,
    fcr_cfg_if.sink            i_cfg,
    fcr_out_if.source          o_out
);

    localparam int BW  = fcr_pkg::BYTE_W;
    localparam int AW  = fcr_pkg::ADDR_W;
    localparam int CMW = fcr_pkg::CMD_W;
    localparam int LW  = $clog2(SECTOR_BYTES + 1);

    logic [BW-1:0]  r_status,      n_status;
    logic           r_pos_mode,    n_pos_mode;
    logic [CMW-1:0] r_last_cmd,    n_last_cmd;
    logic [BW-1:0]  r_head_track,  n_head_track;
    logic           r_step_in,     n_step_in;
    logic [BW-1:0]  r_data_latch,  n_data_latch;
    logic [BW-1:0]  r_sector,      n_sector;
    logic [BW-1:0]  r_side,        n_side;
    logic [AW-1:0]  r_byte_ptr,    n_byte_ptr;
    logic [LW-1:0]  r_bytes_left,  n_bytes_left;
    logic           r_disk_present;
    logic           r_out_valid;
    logic [BW-1:0]  r_out_data,    n_out_data;
    logic [AW-1:0]  r_out_addr;

    logic           take;
    logic [CMW-1:0] cmd;
    logic [BW-1:0]  track_in;
    logic [BW-1:0]  track_out;
    logic [AW-1:0]  lin;
    logic [BW-1:0]  stat_rd;

    assign o_pop_ready = !r_out_valid || o_out.ready;
    assign take        = i_pop_valid && o_pop_ready;
    assign cmd         = i_pop_entry.data[BW-1 -: CMW];

    assign o_out.valid        = r_out_valid;
    assign o_out.read_data    = r_out_data;
    assign o_out.disk_address = r_out_addr;
    assign i_cfg.ready        = 1'b1;

    // Head moves, clamped at track 0 and at the last track.
    assign track_in  = (r_head_track < BW'(LAST_TRACK)) ? r_head_track + BW'(1) : r_head_track;
    assign track_out = (r_head_track != '0) ? r_head_track - BW'(1) : r_head_track;

    // Linear sector number; the sum wraps, so sector zero on track 0, side 0 lands at the top of the space.
    assign lin = AW'(r_head_track) * AW'(fcr_pkg::TRACK_SECTORS) + AW'(r_sector) - AW'(1)
               + (r_side[fcr_pkg::SIDE_BIT] ? AW'(fcr_pkg::SIDE_SECTORS) : '0);

    always_comb begin
        stat_rd = r_status | fcr_pkg::STATUS_RD_FLAG;
        if (r_pos_mode) begin
            stat_rd[fcr_pkg::STAT_TRACK0_BIT] = (r_head_track == '0);
            stat_rd[fcr_pkg::STAT_DRQ_BIT]    = ~stat_rd[fcr_pkg::STAT_DRQ_BIT];
        end else begin
            stat_rd[fcr_pkg::STAT_TRACK0_BIT] = 1'b0;
        end
    end

    always_comb begin
        n_status     = r_status;
        n_pos_mode   = r_pos_mode;
        n_last_cmd   = r_last_cmd;
        n_head_track = r_head_track;
        n_step_in    = r_step_in;
        n_data_latch = r_data_latch;
        n_sector     = r_sector;
        n_side       = r_side;
        n_byte_ptr   = r_byte_ptr;
        n_bytes_left = r_bytes_left;
        n_out_data   = fcr_pkg::ZERO_BYTE;
        case (i_pop_entry.kind)
            fcr_pkg::K_STATUS_RD: begin
                n_status   = stat_rd;
                n_out_data = stat_rd;
            end
            fcr_pkg::K_TRACK_RD:    n_out_data = r_head_track;
            fcr_pkg::K_SECTOR_RD:   n_out_data = r_sector;
            fcr_pkg::K_SIDE_RD:     n_out_data = r_side;
            fcr_pkg::K_UNMAPPED_RD: n_out_data = fcr_pkg::NO_DATA;
            fcr_pkg::K_DATA_RD: begin
                if (r_last_cmd != fcr_pkg::CMD_READ_SECTOR) begin
                    n_out_data = fcr_pkg::NO_DATA;
                end else begin
                    if (r_disk_present) begin
                        n_out_data = i_pop_entry.data;
                        n_byte_ptr = r_byte_ptr + AW'(1);
                    end
                    // The count stops at zero; busy and DRQ drop on the last byte only.
                    if (r_bytes_left != '0) begin
                        n_bytes_left = r_bytes_left - LW'(1);
                        if (r_bytes_left == LW'(1)) begin
                            n_status[fcr_pkg::STAT_DRQ_BIT]  = 1'b0;
                            n_status[fcr_pkg::STAT_BUSY_BIT] = 1'b0;
                        end
                    end
                end
            end
            fcr_pkg::K_SECTOR_WR: n_sector     = i_pop_entry.data;
            fcr_pkg::K_DATA_WR:   n_data_latch = i_pop_entry.data;
            fcr_pkg::K_SIDE_WR:   n_side       = i_pop_entry.data;
            fcr_pkg::K_COMMAND_WR: begin
                n_last_cmd = cmd;
                case (cmd)
                    fcr_pkg::CMD_READ_SECTOR: begin
                        n_byte_ptr                       = AW'(lin * AW'(SECTOR_BYTES));
                        n_status[fcr_pkg::STAT_DRQ_BIT]  = 1'b1;
                        n_status[fcr_pkg::STAT_BUSY_BIT] = 1'b1;
                        n_bytes_left                     = LW'(SECTOR_BYTES);
                        n_pos_mode                       = 1'b0;
                    end
                    fcr_pkg::CMD_RESTORE, fcr_pkg::CMD_SEEK,
                    fcr_pkg::CMD_STEP, fcr_pkg::CMD_STEP_U,
                    fcr_pkg::CMD_STEP_IN, fcr_pkg::CMD_STEP_IN_U,
                    fcr_pkg::CMD_STEP_OUT, fcr_pkg::CMD_STEP_OUT_U,
                    fcr_pkg::CMD_FORCE_INT: begin
                        n_status[fcr_pkg::STAT_BUSY_BIT] = 1'b0;
                        n_pos_mode                       = 1'b1;
                        case (cmd)
                            fcr_pkg::CMD_RESTORE: n_head_track = '0;
                            fcr_pkg::CMD_SEEK:    n_head_track = r_data_latch;
                            fcr_pkg::CMD_STEP, fcr_pkg::CMD_STEP_U: begin
                                n_head_track = r_step_in ? track_in : track_out;
                            end
                            fcr_pkg::CMD_STEP_IN, fcr_pkg::CMD_STEP_IN_U: begin
                                n_head_track = track_in;
                                n_step_in    = 1'b1;
                            end
                            fcr_pkg::CMD_STEP_OUT, fcr_pkg::CMD_STEP_OUT_U: begin
                                n_head_track = track_out;
                                n_step_in    = 1'b0;
                            end
                            default: n_head_track = r_head_track;
                        endcase
                    end
                    default: n_last_cmd = cmd;
                endcase
            end
            default: n_out_data = fcr_pkg::ZERO_BYTE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status       <= '0;
            r_pos_mode     <= 1'b0;
            r_last_cmd     <= fcr_pkg::CMD_RESTORE;
            r_head_track   <= '0;
            r_step_in      <= 1'b0;
            r_data_latch   <= '0;
            r_sector       <= '0;
            r_side         <= '0;
            r_byte_ptr     <= '0;
            r_bytes_left   <= '0;
            r_disk_present <= 1'b1;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_disk_present <= i_cfg.data;
            end
            if (take) begin
                r_status     <= n_status;
                r_pos_mode   <= n_pos_mode;
                r_last_cmd   <= n_last_cmd;
                r_head_track <= n_head_track;
                r_step_in    <= n_step_in;
                r_data_latch <= n_data_latch;
                r_sector     <= n_sector;
                r_side       <= n_side;
                r_byte_ptr   <= n_byte_ptr;
                r_bytes_left <= n_bytes_left;
                r_out_valid  <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_data <= n_out_data;
            r_out_addr <= n_byte_ptr;
        end
    end

endmodule
